@@ rtl/core/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros shared by the literal parser RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RSL_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define RSL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/core/rsl_pkg.sv @@
// ----------------------------------------------------------------------------
// rsl_pkg
// Shared types and constants of the radix suffix literal parser.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rsl_pkg;

	localparam int unsigned DEFAULT_MAX_LENGTH = 255;
	localparam int unsigned NRUN               = 4;
	localparam int unsigned QDEPTH             = 2;

	localparam int unsigned CHAR_W      = 8;
	localparam int unsigned VALUE_W     = 64;
	localparam int unsigned LEN_OUT_W   = 8;
	localparam int unsigned TDATA_OUT_W = 80;
	localparam int unsigned TUSER_OUT_W = 2;

	typedef enum logic [1:0] {
		RADIX_HEX = 2'd0,
		RADIX_OCT = 2'd1,
		RADIX_BIN = 2'd2,
		RADIX_DEC = 2'd3
	} radix_t;

	// One classified character, handed from the front end to the back end.
	typedef struct packed {
		logic [3:0]      digit;
		logic [NRUN-1:0] dig_ok;
		logic [NRUN-1:0] sfx;
		logic            is_us;
		logic            last;
		logic            skip;
	} cls_t;

endpackage

`default_nettype wire

@@ rtl/core/rsl_front.sv @@
// ----------------------------------------------------------------------------
// rsl_front
// Accepts characters, classifies them per radix and tracks string position.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module rsl_front #(
	parameter int unsigned MAX_LENGTH = rsl_pkg::DEFAULT_MAX_LENGTH
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        s_axis_tvalid,
	output logic                             s_axis_tready,
	input  wire logic [rsl_pkg::CHAR_W-1:0]  s_axis_tdata,
	input  wire logic                        s_axis_tlast,
	input  wire logic                        q_full,
	output logic                             q_push,
	output rsl_pkg::cls_t                    q_cls
);
	import rsl_pkg::*;

	localparam int unsigned PW = $clog2(MAX_LENGTH + 1);

	logic [PW-1:0] pos_q;
	logic          accept;
	logic          at_limit;
	logic [7:0]    c;
	logic [3:0]    d;
	logic          is_num;
	logic          is_hex;

	assign s_axis_tready = !q_full;
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign q_push        = accept;
	assign at_limit      = (pos_q == PW'(MAX_LENGTH));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (accept) begin
			if (s_axis_tlast) begin
				pos_q <= '0;
			end else if (!at_limit) begin
				pos_q <= pos_q + 1'b1;
			end
		end
	end

	always_comb begin
		c      = s_axis_tdata;
		d      = 4'd0;
		is_num = 1'b0;
		is_hex = 1'b0;
		case (c) inside
			["0":"9"]: begin
				is_num = 1'b1;
				is_hex = 1'b1;
				d      = c[3:0];
			end
			["a":"f"], ["A":"F"]: begin
				is_hex = 1'b1;
				d      = c[3:0] + 4'd9;
			end
			default: begin
			end
		endcase

		q_cls.digit             = d;
		q_cls.dig_ok[RADIX_HEX] = is_hex;
		q_cls.dig_ok[RADIX_OCT] = is_num && (d < 4'd8);
		q_cls.dig_ok[RADIX_BIN] = is_num && (d < 4'd2);
		q_cls.dig_ok[RADIX_DEC] = is_num;
		q_cls.sfx[RADIX_HEX]    = c inside {"h", "H", "x", "X"};
		q_cls.sfx[RADIX_OCT]    = c inside {"q", "Q", "o", "O"};
		q_cls.sfx[RADIX_BIN]    = c inside {"b", "B", "y", "Y"};
		q_cls.sfx[RADIX_DEC]    = c inside {"d", "D", "t", "T"};
		q_cls.is_us             = (c == "_");
		q_cls.last              = s_axis_tlast;
		// Characters past the length limit still carry their last flag.
		q_cls.skip              = at_limit;
	end

	`RSL_ASSERT_NEXT(a_pos_restart, clk, arst_n, accept && s_axis_tlast, pos_q == '0, "position did not restart after a last beat")
	`RSL_ASSERT_IMPL(a_no_overrun, clk, arst_n, q_push, !q_full, "character pushed into a full queue")

endmodule

`default_nettype wire

@@ rtl/core/rsl_fifo.sv @@
// ----------------------------------------------------------------------------
// rsl_fifo
// Short queue of classified characters between front end and back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module rsl_fifo (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  wire rsl_pkg::cls_t push_data,
	output logic               full,
	input  wire logic          pop,
	output logic               pop_valid,
	output rsl_pkg::cls_t      pop_data
);
	import rsl_pkg::*;

	// Depth is a power of two so the pointers wrap on their own.
	localparam int unsigned QAW = $clog2(QDEPTH);

	cls_t           mem_q [QDEPTH];
	logic [QAW-1:0] wr_q;
	logic [QAW-1:0] rd_q;
	logic [QAW:0]   cnt_q;

	assign full      = (cnt_q == (QAW + 1)'(QDEPTH));
	assign pop_valid = (cnt_q != '0);
	assign pop_data  = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_data;
		end
	end

	`RSL_ASSERT_NEXT(a_push_lands, clk, arst_n, push && !pop, pop_valid, "pushed beat not visible at the read side")

endmodule

`default_nettype wire

@@ rtl/core/rsl_back.sv @@
// ----------------------------------------------------------------------------
// rsl_back
// Runs the four radix accumulators and registers one result per string.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module rsl_back #(
	parameter int unsigned MAX_LENGTH = rsl_pkg::DEFAULT_MAX_LENGTH
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             q_valid,
	input  wire rsl_pkg::cls_t                    q_cls,
	output logic                                  q_pop,
	output logic                                  m_axis_tvalid,
	input  wire logic                             m_axis_tready,
	output logic [rsl_pkg::TDATA_OUT_W-1:0]       m_axis_tdata,
	output logic [rsl_pkg::TUSER_OUT_W-1:0]       m_axis_tuser
);
	import rsl_pkg::*;

	localparam int unsigned PW   = $clog2(MAX_LENGTH + 1);
	localparam int unsigned UW   = (PW + 1 > LEN_OUT_W) ? PW + 1 : LEN_OUT_W;
	localparam int unsigned SW   = VALUE_W + 4;
	localparam int unsigned PADW = TDATA_OUT_W - (VALUE_W + LEN_OUT_W + 2);

	function automatic logic [SW-1:0] scale_by_radix(input logic [VALUE_W-1:0] a,
		input radix_t r);
		logic [SW-1:0] s;
		case (r)
			RADIX_HEX: s = {a, 4'b0000};
			RADIX_OCT: s = {1'b0, a, 3'b000};
			RADIX_BIN: s = {3'b000, a, 1'b0};
			RADIX_DEC: s = {1'b0, a, 3'b000} + {3'b000, a, 1'b0};
			default:   s = '0;
		endcase
		return s;
	endfunction

	logic [VALUE_W-1:0] acc_q [NRUN];
	logic [PW-1:0]      len_q [NRUN];
	logic [NRUN-1:0]    open_q;
	logic [NRUN-1:0]    sfx_q;
	logic [NRUN-1:0]    ovf_q;

	logic [VALUE_W-1:0] acc_n [NRUN];
	logic [PW-1:0]      len_n [NRUN];
	logic [NRUN-1:0]    open_n;
	logic [NRUN-1:0]    sfx_n;
	logic [NRUN-1:0]    ovf_n;

	logic               out_valid_q;
	logic               out_success_q;
	logic [VALUE_W-1:0] out_value_q;
	radix_t             out_kind_q;
	logic [LEN_OUT_W-1:0] out_len_q;
	logic               out_sat_q;

	logic               out_free;
	logic               take;
	logic               res_success;
	logic [VALUE_W-1:0] res_value;
	radix_t             res_kind;
	logic [UW-1:0]      res_used;
	logic               res_sat;

	for (genvar g = 0; g < NRUN; g++) begin : g_run
		localparam radix_t RK = radix_t'(g);
		logic          hold;
		logic          adv;
		logic          close;
		logic          num;
		logic          ovf_hit;
		logic [SW-1:0] sum;

		assign hold    = q_cls.skip || !open_q[g];
		assign adv     = !hold && (q_cls.is_us || q_cls.dig_ok[g]);
		assign close   = !hold && !q_cls.is_us && !q_cls.dig_ok[g];
		assign num     = !hold && !q_cls.is_us && q_cls.dig_ok[g] && !ovf_q[g];
		assign sum     = scale_by_radix(acc_q[g], RK) + SW'(q_cls.digit);
		// Any bit from bit 64 up means the true value passed the saturation point.
		assign ovf_hit = (sum[SW-1:VALUE_W] != '0);

		assign open_n[g] = open_q[g] && !close;
		assign sfx_n[g]  = close ? q_cls.sfx[g] : sfx_q[g];
		assign len_n[g]  = adv ? len_q[g] + 1'b1 : len_q[g];
		assign ovf_n[g]  = ovf_q[g] || (num && ovf_hit);
		assign acc_n[g]  = !num ? acc_q[g] : (ovf_hit ? '1 : sum[VALUE_W-1:0]);
	end

	// Hex, octal and binary need a closed run ended by their suffix; decimal
	// takes its suffix only if present.
	always_comb begin
		res_success = 1'b1;
		res_value   = '0;
		res_kind    = RADIX_HEX;
		res_used    = '0;
		res_sat     = 1'b0;
		if ((len_n[RADIX_HEX] != '0) && !open_n[RADIX_HEX] && sfx_n[RADIX_HEX]) begin
			res_value = acc_n[RADIX_HEX];
			res_kind  = RADIX_HEX;
			res_used  = UW'(len_n[RADIX_HEX]) + UW'(1);
			res_sat   = ovf_n[RADIX_HEX];
		end else if ((len_n[RADIX_OCT] != '0) && !open_n[RADIX_OCT] && sfx_n[RADIX_OCT]) begin
			res_value = acc_n[RADIX_OCT];
			res_kind  = RADIX_OCT;
			res_used  = UW'(len_n[RADIX_OCT]) + UW'(1);
			res_sat   = ovf_n[RADIX_OCT];
		end else if ((len_n[RADIX_BIN] != '0) && !open_n[RADIX_BIN] && sfx_n[RADIX_BIN]) begin
			res_value = acc_n[RADIX_BIN];
			res_kind  = RADIX_BIN;
			res_used  = UW'(len_n[RADIX_BIN]) + UW'(1);
			res_sat   = ovf_n[RADIX_BIN];
		end else if (len_n[RADIX_DEC] != '0) begin
			res_value = acc_n[RADIX_DEC];
			res_kind  = RADIX_DEC;
			res_used  = UW'(len_n[RADIX_DEC])
				+ UW'(!open_n[RADIX_DEC] && sfx_n[RADIX_DEC]);
			res_sat   = ovf_n[RADIX_DEC];
		end else begin
			res_success = 1'b0;
		end
	end

	assign out_free = !out_valid_q || m_axis_tready;
	assign take     = q_valid && (!q_cls.last || out_free);
	assign q_pop    = take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NRUN; i++) begin
				acc_q[i] <= '0;
				len_q[i] <= '0;
			end
			open_q <= '1;
			sfx_q  <= '0;
			ovf_q  <= '0;
		end else if (take) begin
			if (q_cls.last) begin
				for (int i = 0; i < NRUN; i++) begin
					acc_q[i] <= '0;
					len_q[i] <= '0;
				end
				open_q <= '1;
				sfx_q  <= '0;
				ovf_q  <= '0;
			end else begin
				acc_q  <= acc_n;
				len_q  <= len_n;
				open_q <= open_n;
				sfx_q  <= sfx_n;
				ovf_q  <= ovf_n;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (take && q_cls.last) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take && q_cls.last) begin
			out_success_q <= res_success;
			out_value_q   <= res_value;
			out_kind_q    <= res_kind;
			out_len_q     <= res_used[LEN_OUT_W-1:0];
			out_sat_q     <= res_sat;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {{PADW{1'b0}}, out_sat_q, out_len_q, out_value_q, out_success_q};
	assign m_axis_tuser  = out_kind_q;

	`RSL_ASSERT_IMPL(a_fail_zero, clk, arst_n, out_valid_q && !out_success_q, (out_value_q == '0) && (out_len_q == '0) && !out_sat_q && (out_kind_q == RADIX_HEX), "failed parse carries nonzero fields")
	`RSL_ASSERT_NEXT(a_runs_clear, clk, arst_n, take && q_cls.last, (open_q == '1) && (ovf_q == '0) && (sfx_q == '0), "run state not cleared after a last beat")

endmodule

`default_nettype wire

@@ rtl/core/radix_suffix_literal_parser.sv @@
// ----------------------------------------------------------------------------
// radix_suffix_literal_parser
// Parses an unsigned literal with an optional radix suffix, one character
// per beat, and gives one result beat per string.
// ----------------------------------------------------------------------------
// Channel  Dir  Payload
// s_axis   in   tdata[7:0] char_code; tlast last_char
// m_axis   out  tdata success, value, consumed_length, saturated; tuser radix_kind
//
// One character is taken per clock while the queue is not full; the decimal
// multiply-by-ten add works on the 64-bit accumulators in the back end.
// A result beat is registered in the back end once its last character beat
// has passed through the queue.
// Reset clears the run state directly; there is no clearing pass.
// A two-entry queue lets the front keep accepting while the back end waits
// for the result register to drain.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module radix_suffix_literal_parser #(
	parameter int unsigned MAX_LENGTH = rsl_pkg::DEFAULT_MAX_LENGTH
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              s_axis_tvalid,
	output logic                                   s_axis_tready,
	// [7:0] char_code
	input  wire logic [rsl_pkg::CHAR_W-1:0]        s_axis_tdata,
	input  wire logic                              s_axis_tlast,
	output logic                                   m_axis_tvalid,
	input  wire logic                              m_axis_tready,
	// [0] success, [64:1] value, [72:65] consumed_length, [73] saturated, rest zero
	output logic [rsl_pkg::TDATA_OUT_W-1:0]        m_axis_tdata,
	// [1:0] radix_kind
	output logic [rsl_pkg::TUSER_OUT_W-1:0]        m_axis_tuser
);
	import rsl_pkg::*;

	logic q_push;
	logic q_full;
	logic q_pop;
	logic q_valid;
	cls_t push_cls;
	cls_t pop_cls;

	rsl_front #(
		.MAX_LENGTH(MAX_LENGTH)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tlast (s_axis_tlast),
		.q_full       (q_full),
		.q_push       (q_push),
		.q_cls        (push_cls)
	);

	rsl_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_data(push_cls),
		.full     (q_full),
		.pop      (q_pop),
		.pop_valid(q_valid),
		.pop_data (pop_cls)
	);

	rsl_back #(
		.MAX_LENGTH(MAX_LENGTH)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_valid      (q_valid),
		.q_cls        (pop_cls),
		.q_pop        (q_pop),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser)
	);

endmodule

`default_nettype wire

@@ tb/tb_radix_suffix_literal_parser.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_radix_suffix_literal_parser
// Streams strings into the literal parser one character beat at a time.
// A predictor follows the four digit runs and computes the result that each
// string should give. The monitor checks every result beat against it, field
// by field, while both sides idle and stall at random. One long hold-off on
// the result side backs the parser up until it stalls its input.
// ----------------------------------------------------------------------------

module tb_radix_suffix_literal_parser;
	import rsl_pkg::*;

	localparam int MAX_CHARS   = DEFAULT_MAX_LENGTH;
	localparam int RAND_CHARS  = 1100;
	localparam int IDLE_LIMIT  = 4000;
	localparam int LONG_HOLD   = 400;
	localparam int MAX_PRINTS  = 40;

	typedef struct packed {
		logic [7:0] code;
		logic       last;
	} char_beat_t;

	typedef struct packed {
		logic        success;
		logic [63:0] value;
		radix_t      radix;
		logic [7:0]  consumed;
		logic        saturated;
	} literal_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	logic [CHAR_W-1:0]      s_axis_tdata = '0;
	logic                   s_axis_tlast = 1'b0;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	logic [TDATA_OUT_W-1:0] m_axis_tdata;
	logic [TUSER_OUT_W-1:0] m_axis_tuser;

	char_beat_t char_q[$];
	literal_t   parsed_q[$];
	literal_t   due_lit;
	int         errors = 0;
	int         results_seen = 0;
	int         send_gap = 0;
	int         send_calm = 0;
	int         recv_stall = 0;
	int         recv_calm = 0;
	bit         hold_done = 1'b0;
	int         idle_cycles = 0;

	// Predictor copy of the run state.
	int          run_pos;
	logic [63:0] run_acc[4];
	bit          run_open[4];
	logic [8:0]  run_len[4];
	logic [7:0]  run_stop[4];
	bit          run_sat[4];

	string suffix_chars[4] = '{"hHxX", "qQoO", "bByY", "dDtT"};

	radix_suffix_literal_parser dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tlast(s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser)
	);

	always #5 clk = ~clk;

	function automatic int unsigned radix_base(radix_t r);
		case (r)
			RADIX_HEX: return 16;
			RADIX_OCT: return 8;
			RADIX_BIN: return 2;
			default:   return 10;
		endcase
	endfunction

	function automatic int digit_val(radix_t r, logic [7:0] c);
		int d;
		d = -1;
		if (c >= "0" && c <= "9") d = c - "0";
		else if (c >= "a" && c <= "f") d = c - "a" + 10;
		else if (c >= "A" && c <= "F") d = c - "A" + 10;
		if (d >= int'(radix_base(r))) d = -1;
		return d;
	endfunction

	function automatic bit is_suffix(radix_t r, logic [7:0] c);
		string set;
		set = suffix_chars[r];
		return c == set[0] || c == set[1] || c == set[2] || c == set[3];
	endfunction

	task automatic clear_runs();
		run_pos = 0;
		for (int k = 0; k < NRUN; k++) begin
			run_acc[k]  = '0;
			run_open[k] = 1'b1;
			run_len[k]  = '0;
			run_stop[k] = '0;
			run_sat[k]  = 1'b0;
		end
	endtask

	// Advances all four runs by one accepted character and, on the last
	// character of a string, queues the result the parser should give.
	task automatic scan_char(input logic [7:0] c, input logic last);
		int          d;
		int          win;
		logic [71:0] grown;
		logic [8:0]  used;
		literal_t    res;
		if (run_pos < MAX_CHARS) begin
			for (int k = 0; k < NRUN; k++) begin
				if (run_open[k]) begin
					d = digit_val(radix_t'(k), c);
					if (c == "_") begin
						run_len[k]++;
					end else if (d < 0) begin
						run_open[k] = 1'b0;
						run_stop[k] = c;
					end else begin
						run_len[k]++;
						if (!run_sat[k]) begin
							grown = {8'd0, run_acc[k]} * 72'(radix_base(radix_t'(k))) + 72'(d);
							if (grown[71:64] != '0) begin
								run_sat[k] = 1'b1;
								run_acc[k] = '1;
							end else begin
								run_acc[k] = grown[63:0];
							end
						end
					end
				end
			end
			run_pos++;
		end
		if (last) begin
			win = -1;
			used = '0;
			// Suffixed radixes take precedence over the bare decimal run.
			for (int k = 0; k < 3; k++) begin
				if (win < 0 && run_len[k] > 0 && !run_open[k]
						&& is_suffix(radix_t'(k), run_stop[k])) begin
					win = k;
					used = run_len[k] + 9'd1;
				end
			end
			if (win < 0 && run_len[RADIX_DEC] > 0) begin
				win = RADIX_DEC;
				used = run_len[RADIX_DEC];
				if (!run_open[RADIX_DEC] && is_suffix(RADIX_DEC, run_stop[RADIX_DEC]))
					used++;
			end
			res = '0;
			if (win >= 0) begin
				res.success   = 1'b1;
				res.value     = run_acc[win];
				res.radix     = radix_t'(win);
				res.consumed  = used[7:0];
				res.saturated = run_sat[win];
			end
			parsed_q.push_back(res);
			clear_runs();
		end
	endtask

	function automatic int pause_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 90) return $urandom_range(1, 3);
		if (r < 98) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [7:0] digit_char(radix_t r);
		int v;
		v = $urandom_range(0, radix_base(r) - 1);
		if (v < 10) return 8'("0" + v);
		return $urandom_range(0, 1) ? 8'("a" + v - 10) : 8'("A" + v - 10);
	endfunction

	function automatic logic [7:0] any_char();
		string set;
		case ($urandom_range(0, 9))
			0, 1, 2: return 8'("0" + $urandom_range(0, 9));
			3:       return 8'("a" + $urandom_range(0, 5));
			4:       return 8'("A" + $urandom_range(0, 5));
			5, 6: begin
				set = suffix_chars[$urandom_range(0, 3)];
				return set[$urandom_range(0, 3)];
			end
			7:       return "_";
			8:       return 8'h00;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	task automatic push_char(input logic [7:0] c, input logic last);
		char_beat_t b;
		b.code = c;
		b.last = last;
		char_q.push_back(b);
	endtask

	task automatic push_text(input string s);
		for (int i = 0; i < s.len(); i++)
			push_char(s[i], i == s.len() - 1);
	endtask

	task automatic push_word(input logic [7:0] word[$]);
		for (int i = 0; i < word.size(); i++)
			push_char(word[i], i == word.size() - 1);
	endtask

	// Mostly well-formed literals with random digits, underscores and suffix
	// letters; the rest is noise from a mixed alphabet.
	task automatic gen_string();
		logic [7:0] word[$];
		radix_t     r;
		int         n;
		string      set;
		if ($urandom_range(0, 99) < 70) begin
			r = radix_t'($urandom_range(0, 3));
			if ($urandom_range(0, 9) == 0) begin
				// Lengths around and past the 64-bit limit in this radix.
				case (r)
					RADIX_HEX: n = $urandom_range(16, 24);
					RADIX_OCT: n = $urandom_range(21, 30);
					RADIX_BIN: n = $urandom_range(63, 72);
					default:   n = $urandom_range(19, 26);
				endcase
			end else begin
				n = $urandom_range(1, 12);
			end
			for (int i = 0; i < n; i++)
				word.push_back(($urandom_range(0, 99) < 15) ? 8'("_") : digit_char(r));
			if ($urandom_range(0, 99) < ((r == RADIX_DEC) ? 50 : 85)) begin
				set = suffix_chars[r];
				word.push_back(set[$urandom_range(0, 3)]);
			end
			if ($urandom_range(0, 99) < 40) begin
				n = $urandom_range(1, 4);
				for (int i = 0; i < n; i++)
					word.push_back(any_char());
			end
		end else begin
			n = $urandom_range(1, 10);
			for (int i = 0; i < n; i++)
				word.push_back(any_char());
		end
		push_word(word);
	endtask

	task automatic flag_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		errors++;
		if (errors <= MAX_PRINTS)
			$display("%0t %s: got %0h, expected %0h", $time, what, got, want);
	endtask

	// Character source.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata  <= '0;
			s_axis_tlast  <= 1'b0;
		end else begin
			if (s_axis_tvalid && s_axis_tready)
				scan_char(s_axis_tdata, s_axis_tlast);
			if (!s_axis_tvalid || s_axis_tready) begin
				if (send_gap > 0) begin
					s_axis_tvalid <= 1'b0;
					send_gap <= send_gap - 1;
				end else if (char_q.size() > 0) begin
					s_axis_tdata  <= char_q[0].code;
					s_axis_tlast  <= char_q[0].last;
					s_axis_tvalid <= 1'b1;
					void'(char_q.pop_front());
					if (send_calm > 0) begin
						send_gap  <= 0;
						send_calm <= send_calm - 1;
					end else begin
						send_gap <= pause_len();
						if ($urandom_range(0, 39) == 0)
							send_calm <= $urandom_range(30, 120);
					end
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// Result sink backpressure, with one long hold-off early in the run.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else if (!hold_done && results_seen >= 8) begin
			m_axis_tready <= 1'b0;
			recv_stall    <= LONG_HOLD;
			hold_done     <= 1'b1;
		end else if (recv_stall > 0) begin
			m_axis_tready <= 1'b0;
			recv_stall    <= recv_stall - 1;
		end else if (recv_calm > 0) begin
			m_axis_tready <= 1'b1;
			recv_calm     <= recv_calm - 1;
		end else begin
			if ($urandom_range(0, 1) == 0) begin
				m_axis_tready <= 1'b0;
				recv_stall    <= $urandom_range(0, 3);
			end else begin
				m_axis_tready <= 1'b1;
				recv_stall    <= pause_len();
			end
			if ($urandom_range(0, 49) == 0)
				recv_calm <= $urandom_range(20, 100);
		end
	end

	// Result checker.
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			results_seen <= results_seen + 1;
			if (parsed_q.size() == 0) begin
				flag_mismatch("result beat with nothing expected", m_axis_tdata[64:1], 64'd0);
			end else begin
				due_lit = parsed_q.pop_front();
				if (m_axis_tdata[0] !== due_lit.success)
					flag_mismatch("success", m_axis_tdata[0], due_lit.success);
				if (m_axis_tdata[64:1] !== due_lit.value)
					flag_mismatch("value", m_axis_tdata[64:1], due_lit.value);
				if (m_axis_tdata[72:65] !== due_lit.consumed)
					flag_mismatch("consumed_length", m_axis_tdata[72:65], due_lit.consumed);
				if (m_axis_tdata[73] !== due_lit.saturated)
					flag_mismatch("saturated", m_axis_tdata[73], due_lit.saturated);
				if (m_axis_tdata[TDATA_OUT_W-1:74] !== '0)
					flag_mismatch("tdata padding", m_axis_tdata[TDATA_OUT_W-1:74], 64'd0);
				if (m_axis_tuser !== due_lit.radix)
					flag_mismatch("radix_kind", m_axis_tuser, due_lit.radix);
			end
		end
	end

	// Ends the run if neither side moves a beat for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("radix_suffix_literal_parser: mismatch");
				$finish;
			end
		end
	end

	initial begin
		logic [7:0] word[$];
		int         strings_made;
		clear_runs();
		// Directed strings: each radix with a suffix, bare decimal, underscores
		// only, no match, a lone NUL and a lone high byte.
		push_text("7fh");
		push_text("17Q");
		push_text("101y");
		push_text("99T");
		push_text("42");
		push_text("__");
		push_text("zz");
		push_char(8'h00, 1'b1);
		push_char(8'hFF, 1'b1);
		push_text("0X");
		strings_made = 0;
		while (char_q.size() < RAND_CHARS) begin
			if (strings_made == 15) begin
				// Over-long string: the hex run saturates and the suffix closes it
				// right at the length cap, so the tail is ignored.
				word.delete();
				for (int i = 0; i < 254; i++)
					word.push_back("1");
				word.push_back("h");
				for (int i = 0; i < 10; i++)
					word.push_back(any_char());
				push_word(word);
			end else if (strings_made == 40) begin
				// Underscores past the cap give a bare decimal zero.
				word.delete();
				for (int i = 0; i < 258; i++)
					word.push_back("_");
				push_word(word);
			end else begin
				gen_string();
			end
			strings_made++;
		end
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		while (char_q.size() != 0 || s_axis_tvalid)
			@(posedge clk);
		while (parsed_q.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (errors == 0)
			$display("radix_suffix_literal_parser: match");
		else
			$display("radix_suffix_literal_parser: mismatch");
		$finish;
	end

endmodule
